// ===== rtl/fspa_pkg.sv =====
package fspa_pkg;

    localparam int SLOTS_PER_CHUNK = 64;
    localparam int MAX_CHUNKS      = 16;
    localparam int STORE_DEPTH     = 1024;

    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int COUNT_W = ADDR_W + 1;
    localparam int CHUNK_W = 5;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;
    // one word per slot: in-use mark above the free-stack link
    localparam int WORD_W  = ADDR_W + 1;

    localparam int CHUNK_FIT   = STORE_DEPTH / SLOTS_PER_CHUNK;
    localparam int CHUNK_MIN   = (MAX_CHUNKS < CHUNK_FIT) ? MAX_CHUNKS : CHUNK_FIT;
    localparam int CHUNK_LIMIT = (CHUNK_MIN == 0) ? 1 : CHUNK_MIN;

    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FIND  = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_CAP     = 3'd1,
        ST_NOT_IN_POOL = 3'd2,
        ST_ALREADY_FREE = 3'd3,
        ST_RANK_RANGE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } t_state;

    // zero reads as one, anything above the limit saturates
    function automatic logic [CHUNK_W-1:0] clamp_chunks(input logic [CHUNK_W-1:0] v);
        logic [CHUNK_W-1:0] res;
        if (v == '0) begin
            res = CHUNK_W'(1);
        end else if (int'(v) > CHUNK_LIMIT) begin
            res = CHUNK_W'(CHUNK_LIMIT);
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== rtl/fspa_ram.sv =====
module fspa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fixed_slot_pool_allocator_unit.sv =====
// channel   direction  transaction marker          payload
// --------  ---------  --------------------------  ----------------------------------
// request   in         start high while busy low   i_func, i_free_slot, i_rank
// result    out        o_valid, one cycle only     o_slot, o_status, o_used_count
// config    in         i_cfg_we                    i_cfg_data (initial chunks)
//
// allocate, free, unknown func and a rank out of range first read the slot word
//   from the single-port slot ram, then update it in the exec state
// find walks the same ram port one slot per cycle from slot zero up to the slot
//   found, one shared compare and counter per step
// the result strobe comes in the cycle after the last busy cycle, the next
//   request may be accepted in that same cycle; the receiver cannot stall
// synchronous active-low reset, no clearing pass: a slot word at or beyond
//   the fresh frontier reads as free, so stale ram contents never show
module fixed_slot_pool_allocator_unit
    import fspa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [ADDR_W-1:0]  i_free_slot,
    input  logic [ADDR_W-1:0]  i_rank,
    output logic               o_valid,
    output logic [ADDR_W-1:0]  o_slot,
    output logic [STAT_W-1:0]  o_status,
    output logic [COUNT_W-1:0] o_used_count,
    input  logic               i_cfg_we,
    input  logic [CHUNK_W-1:0] i_cfg_data
);

    // sequencer
    t_state r_state, n_state;

    // pool state
    logic [ADDR_W-1:0]  r_top,      n_top;
    logic               r_nonempty, n_nonempty;
    logic [COUNT_W-1:0] r_frontier, n_frontier;
    logic [CHUNK_W-1:0] r_chunk,    n_chunk;
    logic [COUNT_W-1:0] r_total,    n_total;

    // latched request
    logic [FUNC_W-1:0]  r_func,  n_func;
    logic [ADDR_W-1:0]  r_fslot, n_fslot;
    logic [ADDR_W-1:0]  r_rank,  n_rank;

    // scan walker: address being issued, address whose data is back, hits so far
    logic [ADDR_W-1:0]  r_scan,  n_scan;
    logic [ADDR_W-1:0]  r_daddr, n_daddr;
    logic [ADDR_W-1:0]  r_seen,  n_seen;

    // result register
    logic               r_valid,  n_valid;
    logic [ADDR_W-1:0]  r_slot,   n_slot;
    t_status            r_status, n_status;

    // slot ram port
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;

    logic               accept;
    logic [COUNT_W-1:0] pool_cap;
    logic [COUNT_W-1:0] grow_need;
    logic               word_mark;
    logic               scan_mark;
    logic               scan_hit;

    assign accept    = start && (r_state == S_IDLE);
    assign pool_cap  = COUNT_W'(int'(r_chunk) * SLOTS_PER_CHUNK);
    assign grow_need = COUNT_W'(r_frontier / SLOTS_PER_CHUNK) + COUNT_W'(1);

    // mark of the latched free slot, only trusted below the frontier
    assign word_mark = ram_rdata[WORD_W-1] && ({1'b0, r_fslot} < r_frontier);
    assign scan_mark = ram_rdata[WORD_W-1] && ({1'b0, r_daddr} < r_frontier);
    assign scan_hit  = scan_mark && (r_seen == r_rank);

    fspa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if ((i_func == FN_FIND) && ({1'b0, i_rank} < r_total)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        n_top      = r_top;
        n_nonempty = r_nonempty;
        n_frontier = r_frontier;
        n_chunk    = r_chunk;
        n_total    = r_total;
        n_func     = r_func;
        n_fslot    = r_fslot;
        n_rank     = r_rank;
        n_scan     = r_scan;
        n_daddr    = r_daddr;
        n_seen     = r_seen;
        n_valid    = 1'b0;
        n_slot     = r_slot;
        n_status   = r_status;
        ram_we     = 1'b0;
        ram_addr   = r_scan;
        ram_wdata  = '0;

        unique case (r_state)
            S_IDLE: begin
                // read the word this request needs, on the accepting edge
                if (i_func == FN_ALLOC) begin
                    ram_addr = r_top;
                end else if (i_func == FN_FREE) begin
                    ram_addr = i_free_slot;
                end else begin
                    ram_addr = '0;
                end
                if (accept) begin
                    n_func  = i_func;
                    n_fslot = i_free_slot;
                    n_rank  = i_rank;
                    n_scan  = ADDR_W'(1);
                    n_daddr = '0;
                    n_seen  = '0;
                end
            end
            S_EXEC: begin
                n_valid  = 1'b1;
                n_slot   = '0;
                n_status = ST_OK;
                case (r_func)
                    FN_ALLOC: begin
                        if (r_nonempty) begin
                            // pop: bottom entry links to itself
                            ram_addr  = r_top;
                            ram_we    = 1'b1;
                            ram_wdata = {1'b1, ram_rdata[ADDR_W-1:0]};
                            n_slot    = r_top;
                            n_total   = r_total + COUNT_W'(1);
                            if (ram_rdata[ADDR_W-1:0] == r_top) begin
                                n_nonempty = 1'b0;
                            end else begin
                                n_top = ram_rdata[ADDR_W-1:0];
                            end
                        end else if ((r_frontier >= pool_cap) &&
                                     (int'(grow_need) > CHUNK_LIMIT)) begin
                            n_status = ST_NO_CAP;
                        end else begin
                            if (r_frontier >= pool_cap) begin
                                n_chunk = CHUNK_W'(grow_need);
                            end
                            ram_addr   = r_frontier[ADDR_W-1:0];
                            ram_we     = 1'b1;
                            ram_wdata  = {1'b1, {ADDR_W{1'b0}}};
                            n_slot     = r_frontier[ADDR_W-1:0];
                            n_frontier = r_frontier + COUNT_W'(1);
                            n_total    = r_total + COUNT_W'(1);
                        end
                    end
                    FN_FREE: begin
                        ram_addr = r_fslot;
                        if ({1'b0, r_fslot} >= pool_cap) begin
                            n_status = ST_NOT_IN_POOL;
                        end else if (!word_mark) begin
                            n_status = ST_ALREADY_FREE;
                        end else begin
                            ram_we     = 1'b1;
                            ram_wdata  = {1'b0, r_nonempty ? r_top : r_fslot};
                            n_top      = r_fslot;
                            n_nonempty = 1'b1;
                            n_total    = r_total - COUNT_W'(1);
                            // last slot back: pool starts over with one chunk
                            if (r_total == COUNT_W'(1)) begin
                                n_chunk    = CHUNK_W'(1);
                                n_top      = '0;
                                n_nonempty = 1'b0;
                                n_frontier = '0;
                            end
                        end
                    end
                    FN_FIND: begin
                        // only a rank out of range comes here
                        n_status = ST_RANK_RANGE;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                ram_addr = r_scan;
                n_scan   = r_scan + ADDR_W'(1);
                n_daddr  = r_scan;
                if (scan_hit) begin
                    n_valid  = 1'b1;
                    n_slot   = r_daddr;
                    n_status = ST_OK;
                end else if (scan_mark) begin
                    n_seen = r_seen + ADDR_W'(1);
                end
            end
            default: begin
                ram_addr = r_scan;
            end
        endcase

        // the user must send config writes only while idle; the block itself does not enforce it
        if (i_cfg_we) begin
            n_chunk = clamp_chunks(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_top      <= '0;
            r_nonempty <= 1'b0;
            r_frontier <= '0;
            r_chunk    <= CHUNK_W'(1);
            r_total    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_top      <= n_top;
            r_nonempty <= n_nonempty;
            r_frontier <= n_frontier;
            r_chunk    <= n_chunk;
            r_total    <= n_total;
            r_valid    <= n_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_fslot  <= n_fslot;
        r_rank   <= n_rank;
        r_scan   <= n_scan;
        r_daddr  <= n_daddr;
        r_seen   <= n_seen;
        r_slot   <= n_slot;
        r_status <= n_status;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_slot       = r_slot;
    assign o_status     = r_status;
    assign o_used_count = r_total;

endmodule

// ===== rtl/fspa_checker.sv =====
module fspa_checker
    import fspa_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input logic [ADDR_W-1:0]  o_slot,
    input logic [STAT_W-1:0]  o_status,
    input logic [COUNT_W-1:0] o_used_count
);

    // an accepted request keeps the unit busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // a result only follows a busy cycle and lands once the unit is idle again
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) && !busy))
        else $error("result strobe without finished request");

    // failed requests report slot zero
    a_error_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_OK)) |-> (o_slot == '0))
        else $error("non-zero slot on error result");

    // no more slots in use than the store holds
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_used_count) <= STORE_DEPTH))
        else $error("used count beyond store depth");

endmodule

bind fixed_slot_pool_allocator_unit fspa_checker u_fspa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_slot       (o_slot),
    .o_status     (o_status),
    .o_used_count (o_used_count)
);

// ===== dv/fixed_slot_pool_allocator_unit_tb.sv =====
`timescale 1ns / 100ps

module fixed_slot_pool_allocator_unit_tb
    import fspa_pkg::*;
();

    // func code 3 has no meaning: the block must answer ok and change nothing
    localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

    // one request transaction as the driver presents it
    typedef struct {
        logic [FUNC_W-1:0] fn;
        logic [ADDR_W-1:0] fslot;
        logic [ADDR_W-1:0] rank;
    } t_pool_request;

    // one result transaction as the block should report it
    typedef struct {
        logic [ADDR_W-1:0]  slot;
        t_status            status;
        logic [COUNT_W-1:0] used;
    } t_pool_reply;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [FUNC_W-1:0]  i_func = '0;
    logic [ADDR_W-1:0]  i_free_slot = '0;
    logic [ADDR_W-1:0]  i_rank = '0;
    logic               o_valid;
    logic [ADDR_W-1:0]  o_slot;
    logic [STAT_W-1:0]  o_status;
    logic [COUNT_W-1:0] o_used_count;
    logic               i_cfg_we = 1'b0;
    logic [CHUNK_W-1:0] i_cfg_data = '0;

    // requests waiting for the driver, replies waiting for the block
    t_pool_request pending_items[$];
    t_pool_reply   due_results[$];

    // shadow of the pool: free-stack links, in-use marks and counters
    logic [ADDR_W-1:0] next_free [STORE_DEPTH];
    bit                slot_busy [STORE_DEPTH];
    logic [ADDR_W-1:0] stack_top;
    bit                stack_live;
    int                frontier;
    int                pool_chunks;
    int                live_total;

    // progress markers that steer the stimulus phases
    int no_cap_seen = 0;
    int pool_restarts = 0;

    // driver / monitor handshake bookkeeping
    bit            req_taken = 1'b0;
    int            gap_left = 0;
    int            gap_pct = 0;
    int            fail_count = 0;
    t_pool_request cur_item;
    t_pool_reply   want;

    fixed_slot_pool_allocator_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_free_slot  (i_free_slot),
        .i_rank       (i_rank),
        .o_valid      (o_valid),
        .o_slot       (o_slot),
        .o_status     (o_status),
        .o_used_count (o_used_count),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    // 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // empty pool, one chunk, nothing on the free stack
    task automatic clear_pool();
        for (int i = 0; i < STORE_DEPTH; i++) begin
            next_free[i] = '0;
            slot_busy[i] = 1'b0;
        end
        stack_top   = '0;
        stack_live  = 1'b0;
        frontier    = 0;
        pool_chunks = 1;
        live_total  = 0;
    endtask

    // applies one request to the shadow pool and returns the reply it earns
    function automatic t_pool_reply serve_request(logic [FUNC_W-1:0] fn,
                                                  logic [ADDR_W-1:0] fslot,
                                                  logic [ADDR_W-1:0] rank);
        t_pool_reply       r;
        logic [ADDR_W-1:0] below;
        int                need;
        int                seen;
        bit                found;
        r.slot   = '0;
        r.status = ST_OK;
        case (fn)
            FN_ALLOC: begin
                if (stack_live) begin
                    // pop the most recently freed slot; bottom entry links to itself
                    below  = next_free[stack_top];
                    r.slot = stack_top;
                    if (below == stack_top) begin
                        stack_live = 1'b0;
                    end else begin
                        stack_top = below;
                    end
                end else begin
                    // frontier at the end of the chunks held: grow if the limit allows
                    if (frontier >= pool_chunks * SLOTS_PER_CHUNK) begin
                        need = frontier / SLOTS_PER_CHUNK + 1;
                        if (need <= CHUNK_LIMIT) begin
                            pool_chunks = need;
                        end else begin
                            r.status = ST_NO_CAP;
                        end
                    end
                    if (r.status == ST_OK) begin
                        r.slot   = ADDR_W'(frontier);
                        frontier = frontier + 1;
                    end
                end
                if (r.status == ST_OK) begin
                    slot_busy[r.slot] = 1'b1;
                    live_total        = live_total + 1;
                end else begin
                    no_cap_seen = no_cap_seen + 1;
                end
            end
            FN_FREE: begin
                if (int'(fslot) >= pool_chunks * SLOTS_PER_CHUNK) begin
                    r.status = ST_NOT_IN_POOL;
                end else if (!slot_busy[fslot]) begin
                    r.status = ST_ALREADY_FREE;
                end else begin
                    slot_busy[fslot] = 1'b0;
                    next_free[fslot] = stack_live ? stack_top : fslot;
                    stack_top        = fslot;
                    stack_live       = 1'b1;
                    live_total       = live_total - 1;
                    // last slot gone: the pool starts over from one chunk
                    if (live_total == 0) begin
                        pool_chunks   = 1;
                        stack_top     = '0;
                        stack_live    = 1'b0;
                        frontier      = 0;
                        pool_restarts = pool_restarts + 1;
                    end
                end
            end
            FN_FIND: begin
                if (int'(rank) >= live_total) begin
                    r.status = ST_RANK_RANGE;
                end else begin
                    seen  = 0;
                    found = 1'b0;
                    for (int i = 0; i < STORE_DEPTH; i++) begin
                        if (!found && slot_busy[i]) begin
                            if (seen == int'(rank)) begin
                                r.slot = ADDR_W'(i);
                                found  = 1'b1;
                            end
                            seen = seen + 1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.used = COUNT_W'(live_total);
        return r;
    endfunction

    // a slot the shadow pool holds as in use, searched from a random point
    function automatic logic [ADDR_W-1:0] pick_live_slot();
        int                base;
        bit                found;
        logic [ADDR_W-1:0] s;
        base  = $urandom_range(STORE_DEPTH - 1);
        found = 1'b0;
        s     = ADDR_W'(base);
        for (int k = 0; k < STORE_DEPTH; k++) begin
            if (!found && slot_busy[(base + k) % STORE_DEPTH]) begin
                s     = ADDR_W'((base + k) % STORE_DEPTH);
                found = 1'b1;
            end
        end
        return s;
    endfunction

    // keeps the driver queue short so that frees follow the pool closely
    task automatic queue_request(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] fslot,
                                 logic [ADDR_W-1:0] rank);
        t_pool_request q;
        while (pending_items.size() >= 2) @(negedge i_clk);
        q.fn    = fn;
        q.fslot = fslot;
        q.rank  = rank;
        pending_items.push_back(q);
    endtask

    // one random request; percentages for allocate, free and find, the rest is noise
    task automatic queue_random(int alloc_pct, int free_pct, int find_pct);
        int                roll;
        logic [ADDR_W-1:0] fs;
        logic [ADDR_W-1:0] rk;
        roll = $urandom_range(99);
        fs   = ADDR_W'($urandom);
        rk   = ADDR_W'($urandom);
        if (roll < alloc_pct) begin
            queue_request(FN_ALLOC, fs, rk);
        end else if (roll < alloc_pct + free_pct) begin
            // mostly a slot in use, now and then any slot at all
            if (live_total != 0 && $urandom_range(9) != 0) fs = pick_live_slot();
            queue_request(FN_FREE, fs, rk);
        end else if (roll < alloc_pct + free_pct + find_pct) begin
            // ranks up to one past the last, sometimes anywhere in the field
            if ($urandom_range(9) != 0) rk = ADDR_W'($urandom_range(live_total));
            queue_request(FN_FIND, fs, rk);
        end else if ($urandom_range(1) == 0) begin
            queue_request(FN_SPARE, fs, rk);
        end else begin
            queue_request(FUNC_W'($urandom), fs, rk);
        end
    endtask

    // block idle: nothing queued, nothing in flight, no reply outstanding
    task automatic wait_until_quiet();
        @(negedge i_clk);
        #1;
        while (pending_items.size() != 0 || start || busy || due_results.size() != 0) begin
            @(negedge i_clk);
            #1;
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_chunks(logic [CHUNK_W-1:0] v);
        wait_until_quiet();
        i_cfg_data <= v;
        i_cfg_we   <= 1'b1;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // driver: presents the next request at the falling edge, holds it until taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !req_taken) begin
            // still waiting for the block to take it
        end else if (gap_left > 0) begin
            start    <= 1'b0;
            gap_left = gap_left - 1;
        end else if (pending_items.size() != 0) begin
            cur_item    = pending_items.pop_front();
            i_func      <= cur_item.fn;
            i_free_slot <= cur_item.fslot;
            i_rank      <= cur_item.rank;
            start       <= 1'b1;
            // idle burst after this transaction, drawn now
            if ($urandom_range(99) < gap_pct) gap_left = $urandom_range(1, 18);
        end else begin
            start <= 1'b0;
        end
    end

    // monitor: checks replies, then records register writes and taken requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            if (o_valid) begin
                if (due_results.size() == 0) begin
                    fail_count = fail_count + 1;
                    $display("%0t unexpected result: slot %0d status %0d used %0d",
                             $time, o_slot, o_status, o_used_count);
                end else begin
                    want = due_results.pop_front();
                    if (o_slot !== want.slot || o_status !== want.status
                        || o_used_count !== want.used) begin
                        fail_count = fail_count + 1;
                        $display("%0t mismatch: expected slot %0d status %0d used %0d,",
                                 $time, want.slot, want.status, want.used,
                                 " got slot %0d status %0d used %0d",
                                 o_slot, o_status, o_used_count);
                    end
                end
            end
            // chunk count register: zero reads as one, saturates at the limit
            if (i_cfg_we) begin
                if (i_cfg_data == '0) begin
                    pool_chunks = 1;
                end else if (int'(i_cfg_data) > CHUNK_LIMIT) begin
                    pool_chunks = CHUNK_LIMIT;
                end else begin
                    pool_chunks = int'(i_cfg_data);
                end
            end
            req_taken = start && !busy;
            if (req_taken) due_results.push_back(serve_request(i_func, i_free_slot, i_rank));
        end
    end

    // stimulus and end of run
    initial begin
        int budget;
        int restarts_at;
        clear_pool();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero must read back as a single chunk
        write_chunks(5'd0);

        // directed: empty pool errors, LIFO reuse, restart after the last free
        gap_pct = 30;
        queue_request(FN_FIND, '0, '0);          // rank beyond an empty pool
        queue_request(FN_FREE, '0, '0);          // slot in pool but never used
        queue_request(FN_FREE, '1, '0);          // slot beyond the one chunk
        queue_request(FN_SPARE, '1, '1);         // unknown func, no effect
        queue_request(FN_ALLOC, '0, '0);
        queue_request(FN_ALLOC, '0, '0);
        queue_request(FN_ALLOC, '1, '1);
        queue_request(FN_FIND, '0, '0);
        queue_request(FN_FIND, '0, 10'd1);
        queue_request(FN_FIND, '0, 10'd2);
        queue_request(FN_FIND, '0, 10'd3);       // one past the last in use
        queue_request(FN_FIND, '0, '1);          // rank at the top of the field
        queue_request(FN_FREE, 10'd1, '0);
        queue_request(FN_FREE, 10'd1, '0);       // double free
        queue_request(FN_ALLOC, '0, '0);         // reuses the freed slot
        queue_request(FN_FREE, 10'd2, '0);
        queue_request(FN_FREE, 10'd0, '0);
        queue_request(FN_ALLOC, '0, '0);         // last freed comes out first
        queue_request(FN_ALLOC, '0, '0);
        queue_request(FN_FREE, 10'd0, '0);
        queue_request(FN_FREE, 10'd1, '0);
        queue_request(FN_FREE, 10'd2, '0);       // pool empties and starts over
        queue_request(FN_ALLOC, '0, '0);
        queue_request(FN_FREE, 10'd0, '0);

        // full chunk range from the top of the register field, bursty sender
        write_chunks(5'd31);
        for (int n = 0; n < 150; n++) queue_random(50, 35, 10);

        // chunk count dropped below the frontier: growth and out-of-pool frees
        write_chunks(5'd1);
        gap_pct = 0;
        for (int n = 0; n < 100; n++) queue_random(50, 35, 10);

        // mostly allocations, the pool grows chunk by chunk
        write_chunks(5'd2);
        gap_pct = 10;
        budget  = 0;
        while (no_cap_seen < 24 && budget < 300) begin
            queue_random(92, 4, 2);
            budget++;
        end

        // mostly frees, towards an empty pool and a restart
        write_chunks(5'd17);
        gap_pct     = 20;
        restarts_at = pool_restarts;
        budget      = 0;
        while (pool_restarts == restarts_at && budget < 250) begin
            queue_random(3, 93, 2);
            budget++;
        end

        // closing stretch back to back, limit written exactly
        write_chunks(5'd16);
        gap_pct = 0;
        for (int n = 0; n < 100; n++) queue_random(50, 35, 10);

        wait_until_quiet();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog, far beyond the slowest run of this stimulus
    initial begin
        #50000000;
        $display("tb: failure");
        $finish;
    end

endmodule
